### rtl/hsv_hue_rotate_pixel_top_assert.svh
// Assertion macros shared by the hue rotation block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef HSV_HUE_ROTATE_PIXEL_TOP_ASSERT_SVH
`define HSV_HUE_ROTATE_PIXEL_TOP_ASSERT_SVH
`ifndef SYNTH
`define HSVHR_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsvhr: same-cycle check failed");
`define HSVHR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsvhr: next-cycle check failed");
`else
`define HSVHR_ASSERT_IMM(lbl, ante, cons)
`define HSVHR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/hsvhr_pkg.sv
package hsvhr_pkg;

  // Default number of fractional bits in the fixed-point HSV values.
  localparam int FRACTION_BITS_DEF = 16;

  // Divider widths: the dividend covers 255 times a hue numerator below 1530,
  // and the divisor covers 6 * (max - min) up to 1530.
  localparam int DIV_DW = 19;
  localparam int DIV_VW = 11;

  // Configuration register indexes.
  localparam logic CFG_IDX_START = 1'b0;
  localparam logic CFG_IDX_RATE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_OFS,
    ST_CHK,
    ST_DGO,
    ST_DWAIT,
    ST_HUE,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic {
    DV_S8,
    DV_H8
  } div_sel_t;

  typedef enum logic [2:0] {
    MU_M1,
    MU_M2,
    MU_P,
    MU_Q,
    MU_T
  } mul_sel_t;

  typedef enum logic [1:0] {
    RK_HSV,
    RK_BLACK,
    RK_GREY
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      in_ready;
    logic      adv_mul;
    logic      adv_add;
    logic      minmax;
    logic      div_start;
    logic      div_capture;
    div_sel_t  div_sel;
    logic      hue_calc;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      out_load;
    res_kind_t out_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_take;
    logic is_black;
    logic div_done;
    logic quot_zero;
    logic out_free;
  } sts_t;

endpackage

### rtl/hsvhr_pix_in_if.sv
interface hsvhr_pix_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic        frame_first;
  logic [15:0] elapsed_ms;

  modport source (
    output valid, red_in, green_in, blue_in, frame_first, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, red_in, green_in, blue_in, frame_first, elapsed_ms,
    output ready
  );
endinterface

### rtl/hsvhr_pix_out_if.sv
interface hsvhr_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       black_passed;

  modport source (
    output valid, red_out, green_out, blue_out, black_passed,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, black_passed,
    output ready
  );
endinterface

### rtl/hsv_hue_rotate_pixel_top.sv
// Hue rotation of RGB pixels. One pixel is processed at a time: a pixel
// flagged first-of-frame first advances the running hue offset by
// rotation_rate * elapsed_ms; the pixel is then converted to 8-bit HSV, its
// hue is offset and it is converted back by the six-sector rule. Black
// pixels return 0,0,0 with black_passed set; grey pixels need only the
// saturation division and colored pixels also the hue division, both on
// the shared one-bit-per-cycle divider of width DW = 19. The fixed-point
// fractions of hue, saturation and value need no divider.
// Each pixel also waits in its last step until the output register is free;
// a new pixel can be taken as soon as the previous one is in the output
// register. Configuration registers must be written only while no pixel is
// in flight; writing the start offset reloads the running offset.
module hsv_hue_rotate_pixel_top #(
  parameter int FRACTION_BITS = hsvhr_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hsvhr_pix_in_if.sink     in_pix,
  hsvhr_pix_out_if.source  out_pix,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);

  hsvhr_pkg::cmd_t cmd;
  hsvhr_pkg::sts_t sts;

  // Sequencer.
  hsvhr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Arithmetic and storage.
  hsvhr_dp #(
    .F (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

### rtl/hsvhr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module hsvhr_div #(
  parameter int DW = 24,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          qbit;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  // Control: counter, busy and the done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], qbit};
      rem_r <= qbit ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/hsvhr_ctrl.sv
// Sequencer for one pixel: offset advance, HSV divisions, products, output.
module hsvhr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  hsvhr_pkg::sts_t  sts_i,
  output hsvhr_pkg::cmd_t  cmd_o
);

  hsvhr_pkg::state_t    state_r, state_nxt;
  hsvhr_pkg::div_sel_t  dsel_r, dsel_nxt;
  hsvhr_pkg::mul_sel_t  msel_r, msel_nxt;
  hsvhr_pkg::res_kind_t kind_r, kind_nxt;

  // State and step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsvhr_pkg::ST_IDLE;
      dsel_r  <= hsvhr_pkg::DV_S8;
      msel_r  <= hsvhr_pkg::MU_M1;
      kind_r  <= hsvhr_pkg::RK_HSV;
    end else begin
      state_r <= state_nxt;
      dsel_r  <= dsel_nxt;
      msel_r  <= msel_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    msel_nxt  = msel_r;
    kind_nxt  = kind_r;
    cmd_o             = '0;
    cmd_o.div_sel     = dsel_r;
    cmd_o.mul_sel     = msel_r;
    cmd_o.out_kind    = kind_r;

    unique case (state_r)
      hsvhr_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_take) begin
          state_nxt = hsvhr_pkg::ST_ADV;
        end
      end
      hsvhr_pkg::ST_ADV: begin
        cmd_o.adv_mul = 1'b1;
        state_nxt     = hsvhr_pkg::ST_OFS;
      end
      hsvhr_pkg::ST_OFS: begin
        cmd_o.adv_add = 1'b1;
        cmd_o.minmax  = 1'b1;
        state_nxt     = hsvhr_pkg::ST_CHK;
      end
      hsvhr_pkg::ST_CHK: begin
        if (sts_i.is_black) begin
          kind_nxt  = hsvhr_pkg::RK_BLACK;
          state_nxt = hsvhr_pkg::ST_OUT;
        end else begin
          dsel_nxt  = hsvhr_pkg::DV_S8;
          state_nxt = hsvhr_pkg::ST_DGO;
        end
      end
      hsvhr_pkg::ST_DGO: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = hsvhr_pkg::ST_DWAIT;
      end
      hsvhr_pkg::ST_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          unique case (dsel_r)
            hsvhr_pkg::DV_S8: begin
              if (sts_i.quot_zero) begin
                kind_nxt  = hsvhr_pkg::RK_GREY;
                state_nxt = hsvhr_pkg::ST_OUT;
              end else begin
                dsel_nxt  = hsvhr_pkg::DV_H8;
                state_nxt = hsvhr_pkg::ST_DGO;
              end
            end
            default: begin
              state_nxt = hsvhr_pkg::ST_HUE;
            end
          endcase
        end
      end
      hsvhr_pkg::ST_HUE: begin
        cmd_o.hue_calc = 1'b1;
        msel_nxt       = hsvhr_pkg::MU_M1;
        state_nxt      = hsvhr_pkg::ST_MUL;
      end
      hsvhr_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        unique case (msel_r)
          hsvhr_pkg::MU_M1: msel_nxt = hsvhr_pkg::MU_M2;
          hsvhr_pkg::MU_M2: msel_nxt = hsvhr_pkg::MU_P;
          hsvhr_pkg::MU_P:  msel_nxt = hsvhr_pkg::MU_Q;
          hsvhr_pkg::MU_Q:  msel_nxt = hsvhr_pkg::MU_T;
          default: begin
            kind_nxt  = hsvhr_pkg::RK_HSV;
            state_nxt = hsvhr_pkg::ST_OUT;
          end
        endcase
      end
      hsvhr_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = hsvhr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hsvhr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/hsvhr_dp.sv
`include "hsv_hue_rotate_pixel_top_assert.svh"

// Datapath: registers, offset accumulator, shared divider and multiplier,
// sector selection and the output register.
module hsvhr_dp #(
  parameter int F = hsvhr_pkg::FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  hsvhr_pix_in_if.sink           in_pix,
  hsvhr_pix_out_if.source        out_pix,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data,
  input  hsvhr_pkg::cmd_t        cmd_i,
  output hsvhr_pkg::sts_t        sts_o
);

  localparam int DW = hsvhr_pkg::DIV_DW;
  localparam int VW = hsvhr_pkg::DIV_VW;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  function automatic logic [7:0] to8(input logic [F:0] x);
    logic [F+8:0] w;
    w = {x, 8'b0} - {8'b0, x};
    return w[F+7:F];
  endfunction

  // An 8-bit value over 255 is the byte repeated without end after the binary
  // point, so its truncated fraction is the top F bits of that pattern; 255
  // itself is exactly one.
  function automatic logic [F:0] frac8(input logic [7:0] c);
    logic [31:0] rep;
    rep = {c, c, c, c};
    if (c == 8'hFF) return ONE;
    return {1'b0, rep[31 -: F]};
  endfunction

  logic [7:0]  r_r, g_r, b_r;
  logic        first_r;
  logic [15:0] ms_r;
  logic [31:0] rate_r, hoff_r, prod_r;
  logic [7:0]  mx_r, mn_r, s8_r, h8_r;
  logic [F:0]  sf_r, vf_r;
  logic [2:0]  sector_r;
  logic [F-1:0] f_r;
  logic [F:0]  m1_r, m2_r, p_r, q_r, t_r;
  logic        out_valid_r;
  logic [7:0]  ro_r, go_r, bo_r;
  logic        blk_r;

  logic        in_take, out_free;
  logic [7:0]  mx_c, mn_c, d;
  logic [10:0] n, d6;
  logic [DW-1:0] div_dd, quot;
  logic [VW-1:0] div_ds;
  logic        div_busy, div_done;
  logic [F:0]  hf_c;
  logic [F-1:0] hsum;
  logic [F+2:0] h6;
  logic [F:0]  mul_a, mul_b;
  logic [2*F+1:0] mul_p;
  logic [F:0]  sel_r, sel_g, sel_b;
  logic [31:0] adv_full;

  assign in_take  = in_pix.valid && cmd_i.in_ready;
  assign out_free = !out_valid_r || out_pix.ready;
  assign in_pix.ready = cmd_i.in_ready;

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_take) begin
      r_r     <= in_pix.red_in;
      g_r     <= in_pix.green_in;
      b_r     <= in_pix.blue_in;
      first_r <= in_pix.frame_first;
      ms_r    <= in_pix.elapsed_ms;
    end
  end

  // Offset advance product; only its low 32 bits matter.
  assign adv_full = rate_r * {16'b0, ms_r};

  always_ff @(posedge clk) begin
    if (cmd_i.adv_mul) begin
      prod_r <= adv_full;
    end
  end

  // Configuration registers and the running hue offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hoff_r <= '0;
      rate_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == hsvhr_pkg::CFG_IDX_START) begin
        hoff_r <= cfg_data;
      end else begin
        rate_r <= cfg_data;
      end
    end else if (cmd_i.adv_add && first_r) begin
      hoff_r <= hoff_r + prod_r;
    end
  end

  // Channel maximum and minimum.
  always_comb begin
    mx_c = r_r;
    if (g_r > mx_c) mx_c = g_r;
    if (b_r > mx_c) mx_c = b_r;
    mn_c = r_r;
    if (g_r < mn_c) mn_c = g_r;
    if (b_r < mn_c) mn_c = b_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.minmax) begin
      mx_r <= mx_c;
      mn_r <= mn_c;
    end
  end

  // Hue numerator per dominant channel; below six times the span when the span is nonzero.
  always_comb begin
    d  = mx_r - mn_r;
    d6 = {1'b0, d, 2'b0} + {2'b0, d, 1'b0};
    if (mx_r == r_r) begin
      if (g_r >= b_r) begin
        n = {3'b0, g_r - b_r};
      end else begin
        n = d6 - {3'b0, b_r - g_r};
      end
    end else if (mx_r == g_r) begin
      n = ({2'b0, d, 1'b0} + {3'b0, b_r}) - {3'b0, r_r};
    end else begin
      n = ({1'b0, d, 2'b0} + {3'b0, r_r}) - {3'b0, g_r};
    end
  end

  // Divider operand selection: saturation, then hue.
  always_comb begin
    div_dd = '0;
    div_ds = '0;
    unique case (cmd_i.div_sel)
      hsvhr_pkg::DV_S8: begin
        div_dd = DW'({d, 8'b0} - {8'b0, d});
        div_ds = VW'(mx_r);
      end
      default: begin
        div_dd = DW'({n, 8'b0} - {8'b0, n});
        div_ds = d6;
      end
    endcase
  end

  hsvhr_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.div_start),
    .dividend (div_dd),
    .divisor  (div_ds),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // Quotient capture.
  always_ff @(posedge clk) begin
    if (cmd_i.div_capture) begin
      case (cmd_i.div_sel)
        hsvhr_pkg::DV_S8: s8_r <= quot[7:0];
        default:          h8_r <= quot[7:0];
      endcase
    end
  end

  // Offset hue, then split six times the hue into sector and fraction.
  assign hf_c = frac8(h8_r);
  assign hsum = hf_c[F-1:0] + hoff_r[31 -: F];
  assign h6   = {hsum, 2'b0} + {1'b0, hsum, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd_i.hue_calc) begin
      sector_r <= h6[F+2:F];
      f_r      <= h6[F-1:0];
      sf_r     <= frac8(s8_r);
      vf_r     <= frac8(mx_r);
    end
  end

  // Shared multiplier, one product per cycle.
  always_comb begin
    unique case (cmd_i.mul_sel)
      hsvhr_pkg::MU_M1: begin
        mul_a = sf_r;
        mul_b = {1'b0, f_r};
      end
      hsvhr_pkg::MU_M2: begin
        mul_a = sf_r;
        mul_b = ONE - {1'b0, f_r};
      end
      hsvhr_pkg::MU_P: begin
        mul_a = vf_r;
        mul_b = ONE - sf_r;
      end
      hsvhr_pkg::MU_Q: begin
        mul_a = vf_r;
        mul_b = ONE - m1_r;
      end
      default: begin
        mul_a = vf_r;
        mul_b = ONE - m2_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        hsvhr_pkg::MU_M1: m1_r <= mul_p[2*F:F];
        hsvhr_pkg::MU_M2: m2_r <= mul_p[2*F:F];
        hsvhr_pkg::MU_P:  p_r  <= mul_p[2*F:F];
        hsvhr_pkg::MU_Q:  q_r  <= mul_p[2*F:F];
        default:          t_r  <= mul_p[2*F:F];
      endcase
    end
  end

  // Six-sector channel assignment.
  always_comb begin
    case (sector_r)
      3'd0: begin sel_r = vf_r; sel_g = t_r;  sel_b = p_r;  end
      3'd1: begin sel_r = q_r;  sel_g = vf_r; sel_b = p_r;  end
      3'd2: begin sel_r = p_r;  sel_g = vf_r; sel_b = t_r;  end
      3'd3: begin sel_r = p_r;  sel_g = q_r;  sel_b = vf_r; end
      3'd4: begin sel_r = t_r;  sel_g = p_r;  sel_b = vf_r; end
      default: begin sel_r = vf_r; sel_g = p_r; sel_b = q_r; end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        hsvhr_pkg::RK_BLACK: begin
          ro_r <= '0; go_r <= '0; bo_r <= '0; blk_r <= 1'b1;
        end
        hsvhr_pkg::RK_GREY: begin
          ro_r <= mx_r; go_r <= mx_r; bo_r <= mx_r; blk_r <= 1'b0;
        end
        default: begin
          ro_r  <= to8(sel_r);
          go_r  <= to8(sel_g);
          bo_r  <= to8(sel_b);
          blk_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.red_out      = ro_r;
  assign out_pix.green_out    = go_r;
  assign out_pix.blue_out     = bo_r;
  assign out_pix.black_passed = blk_r;

  always_comb begin
    sts_o           = '0;
    sts_o.in_take   = in_take;
    sts_o.is_black  = (mx_r == 8'd0);
    sts_o.div_done  = div_done;
    sts_o.quot_zero = (quot == '0);
    sts_o.out_free  = out_free;
  end

  // A new division is never launched over one in flight.
  `HSVHR_ASSERT_IMM(a_div_start_idle, cmd_i.div_start, !div_busy)
  // A finished pixel never overwrites a result not yet taken.
  `HSVHR_ASSERT_IMM(a_out_no_overwrite, cmd_i.out_load, out_free)
  // Once a pixel is taken, no second one is taken in the next cycle.
  `HSVHR_ASSERT_NXT(a_one_at_a_time, in_take, !cmd_i.in_ready)

endmodule
